### rtl/fpsc_pkg.sv
// ============================================================================
// fpsc_pkg - shared constants for the filtered PD servo controller
// Field widths, fixed-point formats, reset values and register indexes.
// ============================================================================
package fpsc_pkg;

    // Filter window and converter width
    localparam int FILTER_DEPTH = 4;
    localparam int SAMPLE_BITS  = 12;

    localparam int PTR_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int CNT_W = $clog2(FILTER_DEPTH + 1);

    // Register and field widths
    localparam int SETPOINT_W = 12;
    localparam int GAIN_W     = 20;
    localparam int PULSE_W    = 15;
    localparam int PW_W       = 16;
    localparam int ERR_W      = 18;
    localparam int CTL_W      = 17;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 3;

    // Q16 formats; error scale is 32 = 2^5 per count
    localparam int Q_FRAC    = 16;
    localparam int ERR_SHIFT = 5;
    localparam int ERR_MAX   = 2 ** (ERR_W - 1) - 1;
    localparam int CTL_ONE   = 2 ** Q_FRAC;

    // Internal datapath widths
    localparam int VAL_W     = (SAMPLE_BITS > SETPOINT_W) ? SAMPLE_BITS : SETPOINT_W;
    localparam int DACC_W    = VAL_W + CNT_W + 1;
    localparam int DIVD_W    = DACC_W + ERR_SHIFT;
    localparam int DIV_CNT_W = $clog2(DIVD_W);
    localparam int HV_W      = ERR_W + 4;
    localparam int VQ_W      = HV_W + GAIN_W - Q_FRAC;
    localparam int MCNT_W    = $clog2((GAIN_W > CTL_W) ? GAIN_W : CTL_W);

    // Register reset values
    localparam logic [SETPOINT_W-1:0] SETPOINT_RST = SETPOINT_W'(2048);
    localparam logic [GAIN_W-1:0]     KP_RST       = GAIN_W'(52429);
    localparam logic [GAIN_W-1:0]     KD_RST       = GAIN_W'(491520);
    localparam logic [PULSE_W-1:0]    PMIN_RST     = PULSE_W'(1000);
    localparam logic [PULSE_W-1:0]    PSPAN_RST    = PULSE_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT   = 3'd0,
        CFG_PROP_GAIN  = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_PULSE_MIN  = 3'd3,
        CFG_PULSE_SPAN = 3'd4
    } cfg_index_t;

endpackage

### rtl/fpsc_divider.sv
// ============================================================================
// fpsc_divider - bit-serial signed divider for the normalized error
// Computes (dividend * 32) / divisor, truncated toward zero, one quotient bit
// per cycle, and saturates the result to the signed error range.
// ============================================================================
module fpsc_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [fpsc_pkg::DACC_W-1:0]  dividend,
    input  logic        [fpsc_pkg::CNT_W-1:0]   divisor,
    output logic                                done,
    output logic signed [fpsc_pkg::ERR_W-1:0]   quotient
);

    logic                                busy_reg;
    logic                                fin_reg;
    logic                                done_reg;
    logic [fpsc_pkg::DIV_CNT_W-1:0]      cnt_reg;

    logic                                neg_reg;
    logic [fpsc_pkg::DIVD_W-1:0]         num_reg;
    logic [fpsc_pkg::CNT_W-1:0]          rem_reg;
    logic [fpsc_pkg::CNT_W-1:0]          div_reg;
    logic [fpsc_pkg::DIVD_W-1:0]         q_reg;
    logic signed [fpsc_pkg::ERR_W-1:0]   quot_reg;

    logic [fpsc_pkg::DACC_W-1:0]         mag;
    logic [fpsc_pkg::CNT_W:0]            trial;
    logic                                ge;
    logic [fpsc_pkg::CNT_W-1:0]          rem_step;

    assign mag      = dividend[fpsc_pkg::DACC_W-1] ? fpsc_pkg::DACC_W'(-dividend)
                                                   : fpsc_pkg::DACC_W'(dividend);
    assign trial    = {rem_reg, num_reg[fpsc_pkg::DIVD_W-1]};
    assign ge       = (trial >= {1'b0, div_reg});
    assign rem_step = ge ? fpsc_pkg::CNT_W'(trial - {1'b0, div_reg})
                         : fpsc_pkg::CNT_W'(trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg  <= 1'b0;
            done_reg <= fin_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= fpsc_pkg::DIV_CNT_W'(fpsc_pkg::DIVD_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[fpsc_pkg::DACC_W-1];
            num_reg <= {mag, fpsc_pkg::ERR_SHIFT'(0)};
            rem_reg <= '0;
            div_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[fpsc_pkg::DIVD_W-2:0], 1'b0};
            rem_reg <= rem_step;
            q_reg   <= {q_reg[fpsc_pkg::DIVD_W-2:0], ge};
        end

        // saturate and apply the sign once the magnitude is complete
        if (fin_reg)
        begin
            if (!neg_reg)
            begin
                if (q_reg > fpsc_pkg::DIVD_W'(fpsc_pkg::ERR_MAX))
                    quot_reg <= fpsc_pkg::ERR_W'(fpsc_pkg::ERR_MAX);
                else
                    quot_reg <= q_reg[fpsc_pkg::ERR_W-1:0];
            end
            else
            begin
                if (q_reg > fpsc_pkg::DIVD_W'(fpsc_pkg::ERR_MAX + 1))
                    quot_reg <= fpsc_pkg::ERR_W'(fpsc_pkg::ERR_MAX + 1);
                else
                    quot_reg <= -q_reg[fpsc_pkg::ERR_W-1:0];
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg && !fin_reg)
        else $error("divider started while busy");

    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(fin_reg) && !busy_reg)
        else $error("divider done without completion");

endmodule

### rtl/filtered_pd_servo_controller.sv
// ============================================================================
// filtered_pd_servo_controller - moving-average filter, PD law, servo mapper
// Averages armed samples over a circular window, forms an error scaled by 32 per
// count, runs a PD law clamped to 0..1 and maps it to a servo pulse width.
// ============================================================================
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-----------------------------------
//  item     | item_valid / item_stall       | action, sample
//  result   | result_valid / result_stall   | pulse_width, error_value,
//           |                               | control_value, armed_flag
//  config   | cfg_write                     | cfg_index, cfg_data
//
//  An armed tick sums the valid entries (at most FILTER_DEPTH), divides, runs the
//  gain multiply bit by bit, clamps to 0..1, runs the pulse multiply bit by bit
//  and loads the output register; a toggle or a disarmed tick finishes at once
//  with zero values. The next item is taken once the finished result has moved
//  into the output register, where it waits while the next item runs. Reset
//  initializes control state, armed, pointer, fill flag, previous error, config.
// ============================================================================
module filtered_pd_servo_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 action,
    input  logic [fpsc_pkg::SAMPLE_BITS-1:0]     sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [fpsc_pkg::PW_W-1:0]            pulse_width,
    output logic signed [fpsc_pkg::ERR_W-1:0]    error_value,
    output logic [fpsc_pkg::CTL_W-1:0]           control_value,
    output logic                                 armed_flag,
    input  logic                                 cfg_write,
    input  logic [fpsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fpsc_pkg::CFG_W-1:0]           cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SUM    = 6'b000010,
        S_DIV    = 6'b000100,
        S_MUL_V  = 6'b001000,
        S_CLAMP  = 6'b010000,
        S_MUL_P  = 6'b100000
    } state_t;

    // ---- configuration registers ----
    logic [fpsc_pkg::SETPOINT_W-1:0]  setpoint_reg;
    logic [fpsc_pkg::GAIN_W-1:0]      kp_reg;
    logic [fpsc_pkg::GAIN_W-1:0]      kd_reg;
    logic [fpsc_pkg::PULSE_W-1:0]     pulse_min_reg;
    logic [fpsc_pkg::PULSE_W-1:0]     pulse_span_reg;

    // ---- control state ----
    state_t                             state_reg, state_next;
    logic                               finish_reg, finish_next;
    logic                               armed_reg, armed_next;
    logic signed [fpsc_pkg::ERR_W-1:0]  prev_err_reg, prev_err_next;
    logic [fpsc_pkg::PTR_W-1:0]         wp_reg, wp_next;
    logic                               full_reg, full_next;
    logic                               result_valid_reg, result_valid_next;
    logic                               div_go_reg, div_go_next;
    logic [fpsc_pkg::PTR_W-1:0]         idx_reg, idx_next;
    logic [fpsc_pkg::CNT_W-1:0]         n_reg, n_next;
    logic [fpsc_pkg::MCNT_W-1:0]        mcnt_reg, mcnt_next;

    // ---- datapath ----
    logic [fpsc_pkg::SAMPLE_BITS-1:0]     window_reg [fpsc_pkg::FILTER_DEPTH];
    logic signed [fpsc_pkg::DACC_W-1:0]   dacc_reg, dacc_next;
    logic signed [fpsc_pkg::ERR_W-1:0]    e_reg, e_next;
    logic signed [fpsc_pkg::ERR_W:0]      de_reg, de_next;
    logic [fpsc_pkg::GAIN_W-1:0]          kp_sh_reg, kp_sh_next;
    logic [fpsc_pkg::GAIN_W-1:0]          kd_sh_reg, kd_sh_next;
    logic signed [fpsc_pkg::HV_W-1:0]     h_reg, h_next;
    logic [fpsc_pkg::GAIN_W-1:0]          l_reg, l_next;
    logic [fpsc_pkg::CTL_W-1:0]           u_reg, u_next;
    logic [fpsc_pkg::CTL_W-1:0]           u_sh_reg, u_sh_next;
    logic [fpsc_pkg::PULSE_W-1:0]         ph_reg, ph_next;
    logic                                 lb_reg, lb_next;

    logic [fpsc_pkg::PW_W-1:0]            pw_out_reg;
    logic signed [fpsc_pkg::ERR_W-1:0]    err_out_reg;
    logic [fpsc_pkg::CTL_W-1:0]           ctl_out_reg;
    logic                                 armed_out_reg;

    logic                                 win_we;
    logic                                 out_load;
    logic                                 wrap;
    logic                                 sum_last;
    logic                                 div_done;
    logic signed [fpsc_pkg::ERR_W-1:0]    div_quot;
    logic signed [fpsc_pkg::HV_W-1:0]     av, bv, tv;
    logic signed [fpsc_pkg::VQ_W-1:0]     vq;
    logic [fpsc_pkg::CTL_W-1:0]           u_clamp;
    logic [fpsc_pkg::PULSE_W:0]           ap, tp;
    logic [fpsc_pkg::PW_W-1:0]            pw_sum;

    fpsc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (dacc_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign item_stall = (state_reg != S_IDLE) || finish_reg;

    assign wrap     = (wp_reg == fpsc_pkg::PTR_W'(fpsc_pkg::FILTER_DEPTH - 1));
    assign sum_last = ((fpsc_pkg::CNT_W'(idx_reg) + 1'b1) == n_reg);

    // error multiply step: both gains scan their bits LSB first
    assign av = kp_sh_reg[0] ? fpsc_pkg::HV_W'(e_reg)  : '0;
    assign bv = kd_sh_reg[0] ? fpsc_pkg::HV_W'(de_reg) : '0;
    assign tv = h_reg + av + bv;

    // floor of the Q16 product is the high part plus the top low bits
    assign vq = $signed({h_reg, l_reg[fpsc_pkg::GAIN_W-1:fpsc_pkg::Q_FRAC]});

    always_comb
    begin
        if (vq[fpsc_pkg::VQ_W-1])
            u_clamp = '0;
        else if (vq > fpsc_pkg::VQ_W'(fpsc_pkg::CTL_ONE))
            u_clamp = fpsc_pkg::CTL_W'(fpsc_pkg::CTL_ONE);
        else
            u_clamp = vq[fpsc_pkg::CTL_W-1:0];
    end

    // pulse multiply step: control value scans its bits LSB first
    assign ap = u_sh_reg[0] ? {1'b0, pulse_span_reg} : '0;
    assign tp = {1'b0, ph_reg} + ap;

    assign pw_sum = fpsc_pkg::PW_W'(pulse_min_reg) + fpsc_pkg::PW_W'({ph_reg, lb_reg});

    assign out_load = finish_reg && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next        = state_reg;
        finish_next       = finish_reg;
        armed_next        = armed_reg;
        prev_err_next     = prev_err_reg;
        wp_next           = wp_reg;
        full_next         = full_reg;
        result_valid_next = result_valid_reg && result_stall;
        div_go_next       = 1'b0;
        idx_next          = idx_reg;
        n_next            = n_reg;
        mcnt_next         = mcnt_reg;
        dacc_next         = dacc_reg;
        e_next            = e_reg;
        de_next           = de_reg;
        kp_sh_next        = kp_sh_reg;
        kd_sh_next        = kd_sh_reg;
        h_next            = h_reg;
        l_next            = l_reg;
        u_next            = u_reg;
        u_sh_next         = u_sh_reg;
        ph_next           = ph_reg;
        lb_next           = lb_reg;
        win_we            = 1'b0;

        if (out_load)
        begin
            finish_next       = 1'b0;
            result_valid_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && !finish_reg)
                begin
                    if (action || !armed_reg)
                    begin
                        // toggle or disarmed tick: minimum pulse, zero values
                        if (action)
                        begin
                            armed_next = !armed_reg;
                            if (armed_reg)
                                prev_err_next = '0;
                        end
                        e_next      = '0;
                        u_next      = '0;
                        ph_next     = '0;
                        lb_next     = 1'b0;
                        finish_next = 1'b1;
                    end
                    else
                    begin
                        win_we    = 1'b1;
                        wp_next   = wrap ? '0 : wp_reg + 1'b1;
                        full_next = full_reg || wrap;
                        n_next    = (full_reg || wrap)
                                    ? fpsc_pkg::CNT_W'(fpsc_pkg::FILTER_DEPTH)
                                    : fpsc_pkg::CNT_W'(wp_reg) + 1'b1;
                        idx_next  = '0;
                        dacc_next = '0;
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                // accumulate sample minus setpoint over the valid entries
                dacc_next = dacc_reg + fpsc_pkg::DACC_W'(window_reg[idx_reg])
                          - fpsc_pkg::DACC_W'(setpoint_reg);
                idx_next  = idx_reg + 1'b1;
                if (sum_last)
                begin
                    div_go_next = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    e_next     = div_quot;
                    de_next    = (fpsc_pkg::ERR_W + 1)'(div_quot)
                               - (fpsc_pkg::ERR_W + 1)'(prev_err_reg);
                    kp_sh_next = kp_reg;
                    kd_sh_next = kd_reg;
                    h_next     = '0;
                    l_next     = '0;
                    mcnt_next  = '0;
                    state_next = S_MUL_V;
                end
            end
            S_MUL_V:
            begin
                h_next     = tv >>> 1;
                l_next     = {tv[0], l_reg[fpsc_pkg::GAIN_W-1:1]};
                kp_sh_next = kp_sh_reg >> 1;
                kd_sh_next = kd_sh_reg >> 1;
                mcnt_next  = mcnt_reg + 1'b1;
                if (mcnt_reg == fpsc_pkg::MCNT_W'(fpsc_pkg::GAIN_W - 1))
                    state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                u_next        = u_clamp;
                u_sh_next     = u_clamp;
                ph_next       = '0;
                lb_next       = 1'b0;
                mcnt_next     = '0;
                prev_err_next = e_reg;
                state_next    = S_MUL_P;
            end
            S_MUL_P:
            begin
                ph_next   = tp[fpsc_pkg::PULSE_W:1];
                lb_next   = tp[0];
                u_sh_next = u_sh_reg >> 1;
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == fpsc_pkg::MCNT_W'(fpsc_pkg::CTL_W - 1))
                begin
                    finish_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            finish_reg       <= 1'b0;
            armed_reg        <= 1'b0;
            prev_err_reg     <= '0;
            wp_reg           <= '0;
            full_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            div_go_reg       <= 1'b0;
            idx_reg          <= '0;
            n_reg            <= '0;
            mcnt_reg         <= '0;
            setpoint_reg     <= fpsc_pkg::SETPOINT_RST;
            kp_reg           <= fpsc_pkg::KP_RST;
            kd_reg           <= fpsc_pkg::KD_RST;
            pulse_min_reg    <= fpsc_pkg::PMIN_RST;
            pulse_span_reg   <= fpsc_pkg::PSPAN_RST;
        end
        else
        begin
            state_reg        <= state_next;
            finish_reg       <= finish_next;
            armed_reg        <= armed_next;
            prev_err_reg     <= prev_err_next;
            wp_reg           <= wp_next;
            full_reg         <= full_next;
            result_valid_reg <= result_valid_next;
            div_go_reg       <= div_go_next;
            idx_reg          <= idx_next;
            n_reg            <= n_next;
            mcnt_reg         <= mcnt_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    fpsc_pkg::CFG_SETPOINT:
                        setpoint_reg <= cfg_data[fpsc_pkg::SETPOINT_W-1:0];
                    fpsc_pkg::CFG_PROP_GAIN:
                        kp_reg <= cfg_data[fpsc_pkg::GAIN_W-1:0];
                    fpsc_pkg::CFG_DERIV_GAIN:
                        kd_reg <= cfg_data[fpsc_pkg::GAIN_W-1:0];
                    fpsc_pkg::CFG_PULSE_MIN:
                        pulse_min_reg <= cfg_data[fpsc_pkg::PULSE_W-1:0];
                    fpsc_pkg::CFG_PULSE_SPAN:
                        pulse_span_reg <= cfg_data[fpsc_pkg::PULSE_W-1:0];
                    default:
                    begin
                        // drop writes to unused indexes
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
            window_reg[wp_reg] <= sample;
        dacc_reg  <= dacc_next;
        e_reg     <= e_next;
        de_reg    <= de_next;
        kp_sh_reg <= kp_sh_next;
        kd_sh_reg <= kd_sh_next;
        h_reg     <= h_next;
        l_reg     <= l_next;
        u_reg     <= u_next;
        u_sh_reg  <= u_sh_next;
        ph_reg    <= ph_next;
        lb_reg    <= lb_next;
        if (out_load)
        begin
            pw_out_reg    <= pw_sum;
            err_out_reg   <= e_reg;
            ctl_out_reg   <= u_reg;
            armed_out_reg <= armed_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign pulse_width   = pw_out_reg;
    assign error_value   = err_out_reg;
    assign control_value = ctl_out_reg;
    assign armed_flag    = armed_out_reg;

    a_prev_clear_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> (prev_err_reg == '0))
        else $error("previous error kept while disarmed");

    a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !armed_flag) |-> (error_value == '0) && (control_value == '0))
        else $error("disarmed transaction carries nonzero values");

    a_control_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (control_value <= fpsc_pkg::CTL_W'(fpsc_pkg::CTL_ONE)))
        else $error("control value above one");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(finish_reg))
        else $error("result raised without a finished item");

    a_sum_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> armed_reg && (n_reg != '0))
        else $error("window sum while disarmed or empty");

endmodule
